// ----- rtl/rgb_luma_sharpen_pipeline_unit_macros.svh -----
// ----------------------------------------------------------------------------
// rgb_luma_sharpen_pipeline_unit assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef RGB_LUMA_SHARPEN_PIPELINE_UNIT_MACROS_SVH
`define RGB_LUMA_SHARPEN_PIPELINE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lsp_pkg.sv -----
// ----------------------------------------------------------------------------
// lsp_pkg
// Constants, types and helpers of the RGB luma sharpen pipeline.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // coefficients, 8 fraction bits
  localparam logic [7:0] K_YR   = 8'd77;
  localparam logic [7:0] K_YG   = 8'd150;
  localparam logic [7:0] K_YB   = 8'd29;
  localparam logic [9:0] K_CB   = 10'd144;
  localparam logic [9:0] K_CR   = 10'd183;
  localparam logic [9:0] K_R_CR = 10'd359;
  localparam logic [9:0] K_G_CB = 10'd88;
  localparam logic [9:0] K_G_CR = 10'd183;
  localparam logic [9:0] K_B_CB = 10'd454;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic              real_px;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              has_result;
    logic              top_ok;
    logic              bot_ok;
    logic              left_ok;
    logic              right_ok;
    logic              frame_end;
  } lsp_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } lsp_q_stat_t;

  typedef struct packed {
    logic idle;
  } lsp_back_stat_t;

  // floor to integer from 16 fraction bits, saturate to 0..255
  function automatic logic [7:0] to_channel(input logic signed [29:0] v);
    logic [7:0] q;
    if (v[29]) begin
      q = 8'd0;
    end else if (v[28:24] != 5'd0) begin
      q = 8'd255;
    end else begin
      q = v[23:16];
    end
    return q;
  endfunction

endpackage

// ----- rtl/lsp_front.sv -----
// ----------------------------------------------------------------------------
// lsp_front
// Config registers, raster counters and per-item classification.
// ----------------------------------------------------------------------------
module lsp_front import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic        kind,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        q_full,
  output logic        push,
  output lsp_entry_t  push_entry
);

  logic [10:0]       frame_width;
  logic [15:0]       frame_height;
  logic [ADDR_W-1:0] column_count;
  logic [15:0]       row_count;
  logic [10:0]       pending_count;

  logic [10:0]        w;
  logic [15:0]        h;
  logic               flushing;
  logic               accept;
  logic signed [17:0] crow;
  logic signed [11:0] ccol;
  logic [11:0]        col_inc;
  logic [16:0]        row_inc;
  logic [ADDR_W-1:0]  col_wrap;

  always_comb begin
    if (frame_width == 11'd0) begin
      w = 11'd1;
    end else if (frame_width > 11'(MAX_WIDTH)) begin
      w = 11'(MAX_WIDTH);
    end else begin
      w = frame_width;
    end
    h = (frame_height == 16'd0) ? 16'd1 : frame_height;
    flushing = (pending_count != 11'd0);

    if (!flushing) begin
      if (column_count != '0) begin
        crow = $signed({2'b00, row_count}) - 18'sd1;
        ccol = $signed(12'(column_count)) - 12'sd1;
      end else begin
        crow = $signed({2'b00, row_count}) - 18'sd2;
        ccol = $signed({1'b0, w}) - 12'sd1;
      end
    end else if (pending_count > w) begin
      crow = $signed({2'b00, h}) - 18'sd2;
      ccol = $signed({1'b0, w}) - 12'sd1;
    end else begin
      crow = $signed({2'b00, h}) - 18'sd1;
      ccol = $signed({1'b0, w}) - $signed({1'b0, pending_count});
    end

    col_inc  = 12'(column_count) + 12'd1;
    row_inc  = {1'b0, row_count} + 17'd1;
    col_wrap = (col_inc >= {1'b0, w}) ? '0 : col_inc[ADDR_W-1:0];
  end

  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = accept && (!kind || flushing);

  always_comb begin
    push_entry.real_px    = !flushing;
    push_entry.addr       = column_count;
    push_entry.red        = red_in;
    push_entry.green      = green_in;
    push_entry.blue       = blue_in;
    push_entry.has_result = !crow[17];
    push_entry.top_ok     = (crow > 18'sd0);
    push_entry.bot_ok     = ((crow + 18'sd1) < $signed({2'b00, h}));
    push_entry.left_ok    = (ccol > 12'sd0);
    push_entry.right_ok   = ((ccol + 12'sd1) < $signed({1'b0, w}));
    push_entry.frame_end  = flushing && ((crow + 18'sd1) == $signed({2'b00, h}))
                            && ((ccol + 12'sd1) == $signed({1'b0, w}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 11'd8;
      frame_height  <= 16'd8;
      column_count  <= '0;
      row_count     <= '0;
      pending_count <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        if (!flushing) begin
          if (col_inc >= {1'b0, w}) begin
            column_count <= '0;
            if (row_inc >= {1'b0, h}) begin
              row_count     <= '0;
              pending_count <= w + 11'd1;
            end else begin
              row_count <= row_inc[15:0];
            end
          end else begin
            column_count <= col_inc[ADDR_W-1:0];
          end
        end else begin
          pending_count <= pending_count - 11'd1;
          if (pending_count == 11'd1) begin
            column_count <= '0;
            row_count    <= '0;
          end else begin
            column_count <= col_wrap;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/lsp_queue.sv -----
// ----------------------------------------------------------------------------
// lsp_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module lsp_queue import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  lsp_entry_t  push_entry,
  input  logic        pop,
  output lsp_entry_t  head,
  output lsp_q_stat_t stat
);

  lsp_entry_t        slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head       = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/lsp_back.sv -----
// ----------------------------------------------------------------------------
// lsp_back
// Color conversion, line buffers, 3x3 luma window, sharpen and output.
// ----------------------------------------------------------------------------
module lsp_back import lsp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  lsp_entry_t     head,
  input  logic           q_empty,
  output logic           pop,
  output lsp_back_stat_t stat,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [7:0]     red_out,
  output logic [7:0]     green_out,
  output logic [7:0]     blue_out,
  output logic           frame_end
);

  typedef enum logic [2:0] {
    B_IDLE, B_READ, B_UPDATE, B_MULT, B_EMIT
  } state_t;

  state_t     state;
  lsp_entry_t ent;

  logic [15:0] luma0 [MAX_WIDTH];
  logic [15:0] luma1 [MAX_WIDTH];
  logic [33:0] chroma [MAX_WIDTH];
  logic [15:0] rd0;
  logic [15:0] rd1;
  logic [33:0] rdc;

  logic [15:0] y_reg;
  // window taps by position row*3+col; corners in column 0 never read
  logic [15:0] w1, w2, w3, w4, w5, w7, w8;
  logic signed [16:0] hold_cb, hold_cr, cur_cb, cur_cr;
  logic signed [19:0] s_reg;
  logic signed [27:0] p_r_cr, p_g_cb, p_g_cr, p_b_cb;

  logic signed [17:0] bdiff, rdiff;
  logic signed [27:0] cb_prod, cr_prod;
  logic signed [16:0] cb_new, cr_new;
  logic signed [19:0] s_c;
  logic signed [29:0] base, v_r, v_g, v_b;
  logic               mem_wr;
  logic               out_free;
  logic               emit;

  assign pop      = (state == B_IDLE) && !q_empty;
  assign stat.idle = (state == B_IDLE);
  assign mem_wr   = (state == B_UPDATE);
  assign out_free = !result_valid || !result_stall;
  assign emit     = (state == B_EMIT) && ent.has_result && out_free;

  always_comb begin
    bdiff   = $signed({2'b00, ent.blue, 8'd0}) - $signed({2'b00, y_reg});
    rdiff   = $signed({2'b00, ent.red, 8'd0}) - $signed({2'b00, y_reg});
    cb_prod = bdiff * $signed({1'b0, K_CB});
    cr_prod = rdiff * $signed({1'b0, K_CR});
    cb_new  = ent.real_px ? cb_prod[24:8] : 17'sd0;
    cr_new  = ent.real_px ? cr_prod[24:8] : 17'sd0;

    s_c = $signed({4'b0, w4}) * 20'sd5;
    if (ent.top_ok)   s_c = s_c - $signed({4'b0, w1});
    if (ent.bot_ok)   s_c = s_c - $signed({4'b0, w7});
    if (ent.left_ok)  s_c = s_c - $signed({4'b0, w3});
    if (ent.right_ok) s_c = s_c - $signed({4'b0, w5});

    base = $signed({{2{s_reg[19]}}, s_reg, 8'd0});
    v_r  = base + 30'(p_r_cr);
    v_g  = base - 30'(p_g_cb) - 30'(p_g_cr);
    v_b  = base + 30'(p_b_cb);
  end

  // line buffers: registered read in B_READ, write back in B_UPDATE at the same address
  always_ff @(posedge clk) begin
    if (state == B_READ) begin
      rd0 <= luma0[ent.addr];
      rd1 <= luma1[ent.addr];
      rdc <= chroma[ent.addr];
    end
    if (mem_wr) begin
      luma0[ent.addr]  <= rd1;
      luma1[ent.addr]  <= y_reg;
      chroma[ent.addr] <= {cb_new, cr_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      w1 <= '0; w2 <= '0; w3 <= '0; w4 <= '0; w5 <= '0; w7 <= '0; w8 <= '0;
      hold_cb <= '0;
      hold_cr <= '0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent   <= head;
            state <= B_READ;
          end
        end
        B_READ: begin
          y_reg <= ent.real_px ?
                   16'(K_YR * ent.red) + 16'(K_YG * ent.green) + 16'(K_YB * ent.blue)
                   : 16'd0;
          state <= B_UPDATE;
        end
        B_UPDATE: begin
          w1 <= w2;  w2 <= rd0;
          w3 <= w4;  w4 <= w5;  w5 <= rd1;
          w7 <= w8;  w8 <= y_reg;
          cur_cb  <= hold_cb;
          cur_cr  <= hold_cr;
          hold_cb <= rdc[33:17];
          hold_cr <= rdc[16:0];
          state   <= B_MULT;
        end
        B_MULT: begin
          s_reg  <= s_c;
          p_r_cr <= cur_cr * $signed({1'b0, K_R_CR});
          p_g_cb <= cur_cb * $signed({1'b0, K_G_CB});
          p_g_cr <= cur_cr * $signed({1'b0, K_G_CR});
          p_b_cb <= cur_cb * $signed({1'b0, K_B_CB});
          state  <= B_EMIT;
        end
        B_EMIT: begin
          if (!ent.has_result) begin
            state <= B_IDLE;
          end else if (out_free) begin
            red_out      <= to_channel(v_r);
            green_out    <= to_channel(v_g);
            blue_out     <= to_channel(v_b);
            frame_end    <= ent.frame_end;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rgb_luma_sharpen_pipeline_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_luma_sharpen_pipeline_unit
// RGB to YCbCr, 3x3 luma sharpen, back to RGB, for raster pixel streams.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixel channel; each is converted to
// Y/Cb/Cr with 8 fraction bits, luma is sharpened (5 at the center, -1 at
// the four neighbors, zero outside the frame), the center chroma is kept and
// the pixel is converted back to saturated 8-bit RGB. A result appears one
// row plus one pixel after its pixel; after the last pixel of a frame send
// frame_width+1 drain items (kind=1) to flush, the last result carrying
// frame_end. Drains outside a flush are accepted and dropped; a
// pixel sent during a flush acts as a drain. The front classifies and queues
// up to 4 items; for each item the back steps through queue pop, line
// buffer read, read-modify-write of the line buffers and window, multiply
// and emit (held there while the output stalls), and pops no new item
// until it is done with the last. Line buffers need no clearing after reset.
// Config writes (cfg_index 0 frame_width, 1 frame_height) only while idle.
// ----------------------------------------------------------------------------
`include "rgb_luma_sharpen_pipeline_unit_macros.svh"

module rgb_luma_sharpen_pipeline_unit import lsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic        kind,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        frame_end
);

  logic           push;
  lsp_entry_t     push_entry;
  lsp_entry_t     head;
  logic           pop;
  lsp_q_stat_t    q_stat;
  lsp_back_stat_t back_stat;

  // front: counters and classification, one transfer per cycle into the queue while it is not full
  lsp_front u_front (
    .clk, .rst,
    .cfg_write, .cfg_index, .cfg_data,
    .pixel_valid, .pixel_stall,
    .kind, .red_in, .green_in, .blue_in,
    .q_full     (q_stat.full),
    .push,
    .push_entry
  );

  lsp_queue u_queue (
    .clk, .rst,
    .push, .push_entry,
    .pop,
    .head,
    .stat (q_stat)
  );

  // back: line buffers, window, sharpen, output register
  lsp_back u_back (
    .clk, .rst,
    .head,
    .q_empty (q_stat.empty),
    .pop,
    .stat    (back_stat),
    .result_valid, .result_stall,
    .red_out, .green_out, .blue_out, .frame_end
  );

  `LSP_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overfilled")
  `LSP_ASSERT_NEXT(a_back_starts, back_stat.idle && !q_stat.empty, !back_stat.idle, "back stuck idle")
  `LSP_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB luma sharpen pipeline: a cycle-free
// predictor of the YCbCr sharpen path checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  import lsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 5000;  // cycles without any transfer
  localparam int SETTLE      = 40;    // queue depth plus back-end cycles, padded

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = REG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic        kind = 1'b0;
  logic [7:0]  red_in = '0, green_in = '0, blue_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_end;

  rgb_luma_sharpen_pipeline_unit dut (.*);

  always #10 clk = ~clk;

  // ---- predictor state: mirrors line buffers, window and counters ----
  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  pixel_t      sharpened_q[$];     // results still owed by the block
  int unsigned luma_line[2*MAX_WIDTH];
  int          cb_line[MAX_WIDTH];
  int          cr_line[MAX_WIDTH];
  int unsigned luma_win[9];
  int unsigned col_pos, row_pos, drains_owed;
  int          cb_hold, cr_hold;
  int unsigned width_reg = 8, height_reg = 8;

  int  errors = 0;
  int  items_sent = 0;
  bit  idling = 1'b1;              // random gaps on both channels
  int  quiet = 0;

  function automatic logic [7:0] clamp_channel(longint v);
    longint q;
    if (v < 0) return 8'd0;
    q = v >>> 16;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // One accepted item through the predictor; queues a result when one is due.
  task automatic sharpen_predict(logic k_in, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned w, h, k, y, old0, old1;
    int crow, ccol, cb, cr, ccb, ccr;
    bit flushing, real_px;
    longint yy, s, base;
    pixel_t p;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    flushing = drains_owed > 0;
    real_px = !flushing;
    y = 0; cb = 0; cr = 0;
    if (k_in && !flushing) return;  // stray drain is dropped
    k = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
    if (real_px) begin
      if (k > 0) begin crow = row_pos - 1; ccol = k - 1; end
      else begin crow = row_pos - 2; ccol = w - 1; end
    end else if (drains_owed > w) begin
      crow = h - 2; ccol = w - 1;
    end else begin
      crow = h - 1; ccol = w - drains_owed;
    end
    if (real_px) begin
      yy = K_YR * longint'(r) + K_YG * longint'(g) + K_YB * longint'(b);
      y  = 32'(yy);
      cb = int'((longint'(K_CB) * (longint'(b) * 256 - yy)) >>> 8);
      cr = int'((longint'(K_CR) * (longint'(r) * 256 - yy)) >>> 8);
    end
    old0 = luma_line[k];
    old1 = luma_line[MAX_WIDTH + k];
    luma_line[k] = old1;
    luma_line[MAX_WIDTH + k] = y;
    for (int i = 0; i < 3; i++) begin
      luma_win[i*3]   = luma_win[i*3+1];
      luma_win[i*3+1] = luma_win[i*3+2];
    end
    luma_win[2] = old0; luma_win[5] = old1; luma_win[8] = y;
    ccb = cb_hold; ccr = cr_hold;
    cb_hold = cb_line[k]; cr_hold = cr_line[k];
    cb_line[k] = cb; cr_line[k] = cr;
    if (real_px) begin
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin row_pos = 0; drains_owed = w + 1; end
        else row_pos++;
      end else col_pos++;
    end else begin
      drains_owed--;
      if (drains_owed == 0) begin col_pos = 0; row_pos = 0; end
      else col_pos = (col_pos + 1 >= w) ? 0 : col_pos + 1;
    end
    if (crow < 0) return;
    // neighbors outside the frame count as zero
    s = 5 * longint'(luma_win[4]);
    if (crow > 0) s -= luma_win[1];
    if (crow + 1 < h) s -= luma_win[7];
    if (ccol > 0) s -= luma_win[3];
    if (ccol + 1 < w) s -= luma_win[5];
    base    = s * 256;
    p.red   = clamp_channel(base + K_R_CR * longint'(ccr));
    p.green = clamp_channel(base - K_G_CB * longint'(ccb) - K_G_CR * longint'(ccr));
    p.blue  = clamp_channel(base + K_B_CB * longint'(ccb));
    p.last  = !real_px && (crow + 1 == h) && (ccol + 1 == w);
    sharpened_q.push_back(p);
  endtask

  // ---- pixel channel: one transfer; valid stays high into the next item ----
  task automatic send_item(logic k_in, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (idling && $urandom_range(99) < 25) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    kind <= k_in; red_in <= r; green_in <= g; blue_in <= b;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sharpen_predict(k_in, r, g, b);
    items_sent++;
  endtask

  task automatic send_pixel();
    send_item(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
              8'($urandom_range(255)));
  endtask

  // Complete the current frame, then flush it; some flush slots get pixels.
  task automatic finish_frame(int pixel_in_flush_pct);
    while (drains_owed == 0) send_pixel();
    while (drains_owed > 0) begin
      if ($urandom_range(99) < pixel_in_flush_pct) send_pixel();
      else send_item(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
    end
  endtask

  // Pipeline empty: every result in, plus the back end's latency.
  task automatic wait_drained();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sharpened_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) width_reg = val & 16'h07FF;
    else height_reg = val;
  endtask

  task automatic set_frame(logic [15:0] w, logic [15:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // ---- tests ----
  // 3x3 frame with corner colors, a stray drain and a pixel during the flush.
  task automatic test_directed_small();
    set_frame(16'd3, 16'd3);
    send_item(1'b1, 8'hFF, 8'hFF, 8'hFF);  // no flush pending: dropped
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd255, 8'd0, 8'd0);
    send_item(1'b0, 8'd0, 8'd255, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd255);
    send_item(1'b0, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 8'd0);
    send_item(1'b0, 8'd0, 8'd255, 8'd255);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    send_item(1'b0, 8'd77, 8'd88, 8'd99);   // acts as a drain
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 8'd0);
    wait_drained();
  endtask

  // Single-row frame, then zero sizes that behave as one.
  task automatic test_degenerate_sizes();
    set_frame(16'd4, 16'd1);
    finish_frame(0);
    wait_drained();
    set_frame(16'd0, 16'd0);
    finish_frame(0);
    finish_frame(50);
    wait_drained();
  endtask

  // Oversized width write saturates (the row runs on past the old width),
  // then a narrower width wraps the counter; tall height with a mid-frame
  // pause and a height change.
  task automatic test_extremes();
    set_frame(16'hFFFF, 16'd1);
    repeat (20) send_pixel();
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 16'd3);    // column counter wraps on the new bound
    finish_frame(5);
    wait_drained();
    set_frame(16'd3, 16'hFFFF);
    repeat (20) send_pixel();
    wait_drained();                       // sender holds off mid-frame
    repeat (10) send_pixel();
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, 16'd2);   // counters wrap on the new bound
    finish_frame(10);
    wait_drained();
  endtask

  // Random frames, mostly small; stray drains as noise.
  task automatic test_random_frames();
    int target;
    target = items_sent + 400;
    while (items_sent < target) begin
      set_frame(16'($urandom_range(99) < 5 ? 0 : $urandom_range(1, 12)),
                16'($urandom_range(99) < 5 ? 0 : $urandom_range(1, 6)));
      idling = ($urandom_range(5) != 0);  // some frames with no gaps
      repeat ($urandom_range(2)) send_item(1'b1, 8'($urandom_range(255)),
                                           8'($urandom_range(255)),
                                           8'($urandom_range(255)));
      finish_frame(15);
      if ($urandom_range(3) == 0) finish_frame(0);
      wait_drained();
    end
    idling = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_small();
    test_degenerate_sizes();
    test_extremes();
    test_random_frames();
    wait_drained();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ---- result channel: random stall, in-order check ----
  always @(posedge clk) begin
    result_stall <= idling && ($urandom_range(99) < 25);
  end

  always @(posedge clk) begin
    pixel_t e;
    if (!rst && result_valid && !result_stall) begin
      if (sharpened_q.size() == 0) begin
        $error("result transfer with no pixel expected");
        errors++;
      end else begin
        e = sharpened_q.pop_front();
        if (red_out !== e.red) begin
          $error("red_out expected %0d got %0d", e.red, red_out); errors++;
        end
        if (green_out !== e.green) begin
          $error("green_out expected %0d got %0d", e.green, green_out); errors++;
        end
        if (blue_out !== e.blue) begin
          $error("blue_out expected %0d got %0d", e.blue, blue_out); errors++;
        end
        if (frame_end !== e.last) begin
          $error("frame_end expected %0d got %0d", e.last, frame_end); errors++;
        end
      end
    end
  end

  // ---- watchdog: too long without any transfer ----
  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lsp_pkg.sv
rtl/lsp_front.sv
rtl/lsp_queue.sv
rtl/lsp_back.sv
rtl/rgb_luma_sharpen_pipeline_unit.sv
tb/sv/tb_top.sv
